// ===== rtl/hsf_pkg.sv =====
package hsf_pkg;

    // fixed-point constants
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [28:0] BRACKET_BASE = 29'd20643840;    // 315 K in Q16
    localparam logic [15:0] TEQ_FLOOR    = 16'd12800;       // 200 K in Q10.6
    localparam logic [15:0] RATE_MAX     = 16'hFFFF;
    localparam logic [15:0] KT_MIN       = 16'd1638;        // 1/40 per day in Q0.16
    localparam logic [21:0] KT_SAT_LIMIT = 22'd327680;      // 5 * 2^16
    localparam logic [18:0] KT_RECIP     = 19'd419431;      // ceil(2^21 / 5)
    localparam logic [16:0] PREF_RESET   = 17'd100000;

    // pipeline layout
    localparam int LOG_LAT    = 18;
    localparam int W_QB       = 17;
    localparam int TH_QB      = 31;
    localparam int EARLY_DLY  = 16;
    localparam int PIPE_DEPTH = LOG_LAT + 8 + TH_QB + 1;

    typedef struct packed {
        logic [31:0] c2;
        logic [21:0] term60;
        logic [19:0] c4;
        logic        bad;
        logic [17:0] ex;
        logic [15:0] temp;
        logic [17:0] mass;
        logic [15:0] wx;
        logic [15:0] wy;
        logic [15:0] wz;
    } hsf_early_t;

    typedef struct packed {
        logic        bad;
        logic        dtpos;
        logic        ovf;
        logic [15:0] teq;
        logic [15:0] kt;
        logic [15:0] kf;
        logic [31:0] drag_x;
        logic [31:0] drag_y;
        logic [31:0] drag_z;
    } hsf_late_t;

endpackage

// ===== rtl/hsf_point_if.sv =====
interface hsf_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] lat_sin;
    logic [15:0]        lat_cos;
    logic [16:0]        point_pressure;
    logic [16:0]        ground_pressure;
    logic [17:0]        exner_factor;
    logic [15:0]        air_temperature;
    logic [17:0]        layer_mass;
    logic signed [15:0] wind_x;
    logic signed [15:0] wind_y;
    logic signed [15:0] wind_z;

    modport source (
        output valid, lat_sin, lat_cos, point_pressure, ground_pressure,
               exner_factor, air_temperature, layer_mass, wind_x, wind_y, wind_z,
        input  ready
    );
    modport sink (
        input  valid, lat_sin, lat_cos, point_pressure, ground_pressure,
               exner_factor, air_temperature, layer_mass, wind_x, wind_y, wind_z,
        output ready
    );
endinterface

// ===== rtl/hsf_force_if.sv =====
interface hsf_force_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] theta_mass_tendency;
    logic signed [31:0] drag_x;
    logic signed [31:0] drag_y;
    logic signed [31:0] drag_z;
    logic [15:0]        equilibrium_temp;
    logic [15:0]        relax_rate;
    logic [15:0]        drag_rate;
    logic               bad_input;

    modport source (
        output valid, theta_mass_tendency, drag_x, drag_y, drag_z, equilibrium_temp,
               relax_rate, drag_rate, bad_input,
        input  ready
    );
    modport sink (
        input  valid, theta_mass_tendency, drag_x, drag_y, drag_z, equilibrium_temp,
               relax_rate, drag_rate, bad_input,
        output ready
    );
endinterface

// ===== rtl/hsf_dly.sv =====
module hsf_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         adv,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[DEPTH-1];

endmodule

// ===== rtl/hsf_log.sv =====
module hsf_log (
    input  logic        clk,
    input  logic        adv,
    input  logic [16:0] x,
    output logic [20:0] ln_q16
);

    logic [4:0]  k;
    logic [31:0] y0;
    logic [4:0]  k_reg    [17];
    logic [31:0] y_reg    [17];
    logic [15:0] frac_reg [17];
    logic [32:0] t        [16];
    logic [20:0] l2;
    logic [52:0] prod;
    logic [20:0] ln_reg;

    // position of the leading one
    always_comb
    begin
        k = '0;
        for (int j = 1; j < 17; j++)
        begin
            if (x[j])
            begin
                k = 5'(j);
            end
        end
        y0 = 32'(x) << (5'd31 - k);
    end

    // one squaring step per stage, each yields one fraction bit
    always_comb
    begin
        logic [63:0] sq;
        for (int i = 0; i < 16; i++)
        begin
            sq   = 64'(y_reg[i]) * 64'(y_reg[i]);
            t[i] = sq[63:31];
        end
    end

    assign l2   = {k_reg[16], frac_reg[16]};
    assign prod = 53'(l2) * 53'(hsf_pkg::LN2_Q32);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg[0]    <= k;
            y_reg[0]    <= y0;
            frac_reg[0] <= '0;
            for (int i = 0; i < 16; i++)
            begin
                k_reg[i+1] <= k_reg[i];
                if (t[i][32])
                begin
                    y_reg[i+1]    <= t[i][32:1];
                    frac_reg[i+1] <= frac_reg[i] | (16'd1 << (15 - i));
                end
                else
                begin
                    y_reg[i+1]    <= t[i][31:0];
                    frac_reg[i+1] <= frac_reg[i];
                end
            end
            ln_reg <= prod[52:32];
        end
    end

    assign ln_q16 = ln_reg;

endmodule

// ===== rtl/hsf_div.sv =====
module hsf_div #(
    parameter int NW = 50,
    parameter int DW = 20,
    parameter int QB = 31
) (
    input  logic          clk,
    input  logic          adv,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quot
);

    logic [DW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] lo_reg  [QB];
    logic [QB-1:0] q_reg   [QB];

    logic [DW-1:0] r_in  [QB];
    logic [DW-1:0] d_in  [QB];
    logic [QB-1:0] n_in  [QB];
    logic [QB-1:0] q_in  [QB];
    logic [DW:0]   trial [QB];
    logic          take  [QB];

    // restoring division, one quotient bit per stage
    always_comb
    begin
        r_in[0] = DW'(num[NW-1:QB]);
        d_in[0] = den;
        n_in[0] = num[QB-1:0];
        q_in[0] = '0;
        for (int i = 1; i < QB; i++)
        begin
            r_in[i] = rem_reg[i-1];
            d_in[i] = den_reg[i-1];
            n_in[i] = lo_reg[i-1];
            q_in[i] = q_reg[i-1];
        end
        for (int i = 0; i < QB; i++)
        begin
            trial[i] = {r_in[i], n_in[i][QB-1]};
            take[i]  = trial[i] >= {1'b0, d_in[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < QB; i++)
            begin
                if (take[i])
                begin
                    rem_reg[i] <= DW'(trial[i] - {1'b0, d_in[i]});
                end
                else
                begin
                    rem_reg[i] <= DW'(trial[i]);
                end
                den_reg[i] <= d_in[i];
                lo_reg[i]  <= n_in[i] << 1;
                q_reg[i]   <= {q_in[i][QB-2:0], take[i]};
            end
        end
    end

    assign quot = q_reg[QB-1];

endmodule

// ===== rtl/held_suarez_forcing_point_core.sv =====
// channel      dir  handshake     payload
// grid_point   in   valid/ready   latitude, pressures, exner, temperature, mass, wind
// forcing      out  valid/ready   theta tendency, drag x/y/z, teq, rates, bad flag
// cfg_wr_en    in   write strobe  cfg_wr_data -> reference pressure
//
// one beat per cycle in, one per cycle out, while forcing is not stalled
// most of the pipe depth comes from the 16 log squaring stages and the 31-stage theta divider
// rst_n clears the valid bits and sets reference pressure to 100000 Pa
// a stall on forcing freezes the whole pipe; grid_point.ready follows it
module held_suarez_forcing_point_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    hsf_point_if.sink   grid_point,
    hsf_force_if.source forcing
);

    localparam int ND = hsf_pkg::PIPE_DEPTH;

    logic                        adv;
    logic [ND-1:0]               vld_reg;
    logic [16:0]                 pref_reg;

    // stage 1
    logic [15:0] s_raw, sa;
    logic [20:0] p10, ps7, a_next;
    logic        bad_next;
    logic        s1_bad_reg;
    logic [20:0] s1_a_reg;
    logic [18:0] s1_d_reg;
    logic [31:0] s1_c2_reg, s1_sa2_reg;
    logic [17:0] s1_ex_reg, s1_mass_reg;
    logic [15:0] s1_temp_reg, s1_wx_reg, s1_wy_reg, s1_wz_reg;

    // stage 2 and delay
    logic [35:0]         t60, c4sq;
    hsf_pkg::hsf_early_t s2_e_reg, e18;
    logic [20:0]         lp18, lr18;
    logic [16:0]         w18;

    // stages 19..26
    logic signed [21:0]  lnr;
    logic signed [25:0]  lx;
    hsf_pkg::hsf_early_t s19_e_reg, s20_e_reg, s21_e_reg, s22_e_reg;
    hsf_pkg::hsf_early_t s23_e_reg, s24_e_reg, s25_e_reg;
    hsf_pkg::hsf_late_t  s19_l_reg, s20_l_reg, s21_l_reg, s22_l_reg;
    hsf_pkg::hsf_late_t  s23_l_reg, s24_l_reg, s25_l_reg, s26_l_reg, l57;
    hsf_pkg::hsf_late_t  s19_l_next, s21_l_next, s22_l_next;
    hsf_pkg::hsf_late_t  s23_l_next, s24_l_next, s26_l_next;
    logic signed [25:0]  s19_lnr10_reg;
    logic [36:0]         s19_wc4_reg;
    logic [24:0]         lmag;
    logic [56:0]         t2prod;
    logic [40:0]         xsum;
    logic [26:0]         s20_t2_reg;
    logic                s20_t2neg_reg;
    logic [21:0]         s20_xk_reg;
    logic [33:0]         s20_mkf_reg;
    logic [37:0]         kp;
    logic [15:0]         vmx, vmy, vmz;
    logic [28:0]         s21_br_reg;
    logic [49:0]         s21_dpx_reg, s21_dpy_reg, s21_dpz_reg;
    logic                s21_nx_reg, s21_ny_reg, s21_nz_reg;
    logic [27:0]         bmag;
    logic [45:0]         s22_tprod_reg;
    logic                s22_bneg_reg;
    logic [33:0]         s22_mk_reg, s23_mk_reg, s24_mk_reg;
    logic [19:0]         tq;
    logic [16:0]         dt;
    logic [15:0]         s24_adt_reg;
    logic [49:0]         s25_num_reg, s26_num_reg;
    logic [19:0]         s26_den_reg;
    logic [30:0]         q57;

    // output stage
    logic [31:0] qc, theta;
    logic [31:0] o_theta_reg, o_dx_reg, o_dy_reg, o_dz_reg;
    logic [15:0] o_teq_reg, o_kt_reg, o_kf_reg;
    logic        o_bad_reg;

    assign adv              = !vld_reg[ND-1] || forcing.ready;
    assign grid_point.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            pref_reg <= hsf_pkg::PREF_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[ND-2:0], grid_point.valid};
            end
            if (cfg_wr_en)
            begin
                pref_reg <= cfg_wr_data;
            end
        end
    end

    // stage 1: validity, drag-weight numerator and denominator, squares
    always_comb
    begin
        s_raw    = grid_point.lat_sin;
        sa       = s_raw[15] ? (16'd0 - s_raw) : s_raw;
        p10      = (21'(grid_point.point_pressure) << 3) + (21'(grid_point.point_pressure) << 1);
        ps7      = (21'(grid_point.ground_pressure) << 3) - 21'(grid_point.ground_pressure);
        a_next   = (p10 > ps7) ? (p10 - ps7) : '0;
        bad_next = (grid_point.point_pressure == '0) || (grid_point.ground_pressure == '0)
                || (grid_point.point_pressure > grid_point.ground_pressure)
                || (pref_reg == '0) || (grid_point.exner_factor == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bad_reg  <= bad_next;
            s1_a_reg    <= a_next;
            s1_d_reg    <= (19'(grid_point.ground_pressure) << 1)
                         + 19'(grid_point.ground_pressure);
            s1_c2_reg   <= 32'(grid_point.lat_cos) * 32'(grid_point.lat_cos);
            s1_sa2_reg  <= 32'(sa) * 32'(sa);
            s1_ex_reg   <= grid_point.exner_factor;
            s1_mass_reg <= grid_point.layer_mass;
            s1_temp_reg <= grid_point.air_temperature;
            s1_wx_reg   <= grid_point.wind_x;
            s1_wy_reg   <= grid_point.wind_y;
            s1_wz_reg   <= grid_point.wind_z;
        end
    end

    // stage 2: latitude terms
    assign t60  = 36'(s1_sa2_reg) * 36'd60;
    assign c4sq = 36'(s1_c2_reg[31:14]) * 36'(s1_c2_reg[31:14]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_e_reg.c2     <= s1_c2_reg;
            s2_e_reg.term60 <= t60[35:14];
            s2_e_reg.c4     <= c4sq[35:16];
            s2_e_reg.bad    <= s1_bad_reg;
            s2_e_reg.ex     <= s1_ex_reg;
            s2_e_reg.temp   <= s1_temp_reg;
            s2_e_reg.mass   <= s1_mass_reg;
            s2_e_reg.wx     <= s1_wx_reg;
            s2_e_reg.wy     <= s1_wy_reg;
            s2_e_reg.wz     <= s1_wz_reg;
        end
    end

    hsf_dly #(
        .W     ($bits(hsf_pkg::hsf_early_t)),
        .DEPTH (hsf_pkg::EARLY_DLY)
    ) u_early_dly (
        .clk (clk),
        .adv (adv),
        .d   (s2_e_reg),
        .q   (e18)
    );

    hsf_log u_log_p (
        .clk    (clk),
        .adv    (adv),
        .x      (grid_point.point_pressure),
        .ln_q16 (lp18)
    );

    hsf_log u_log_ref (
        .clk    (clk),
        .adv    (adv),
        .x      (pref_reg),
        .ln_q16 (lr18)
    );

    hsf_div #(
        .NW (37),
        .DW (19),
        .QB (hsf_pkg::W_QB)
    ) u_w_div (
        .clk  (clk),
        .adv  (adv),
        .num  ({s1_a_reg[20:0], 16'd0}),
        .den  (s1_d_reg),
        .quot (w18)
    );

    // stage 19: log ratio times 10, w * c4, drag rate
    assign lnr = $signed({1'b0, lp18}) - $signed({1'b0, lr18});
    assign lx  = 26'(lnr);

    always_comb
    begin
        s19_l_next    = '0;
        s19_l_next.kf = w18[16] ? hsf_pkg::RATE_MAX : w18[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s19_e_reg     <= e18;
            s19_lnr10_reg <= (lx <<< 3) + (lx <<< 1);
            s19_wc4_reg   <= 37'(w18) * 37'(e18.c4);
            s19_l_reg     <= s19_l_next;
        end
    end

    // stage 20: cosine-squared log term, relaxation numerator, mass * kf
    assign lmag   = s19_lnr10_reg[25] ? 25'(-s19_lnr10_reg) : 25'(s19_lnr10_reg);
    assign t2prod = 57'(lmag) * 57'(s19_e_reg.c2);
    assign xsum   = (41'd1 << 32) + (41'(s19_wc4_reg) << 3) + 41'(s19_wc4_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s20_e_reg     <= s19_e_reg;
            s20_l_reg     <= s19_l_reg;
            s20_t2_reg    <= t2prod[56:30];
            s20_t2neg_reg <= s19_lnr10_reg[25];
            s20_xk_reg    <= xsum[40:19];
            s20_mkf_reg   <= 34'(s19_e_reg.mass) * 34'(s19_l_reg.kf);
        end
    end

    // stage 21: bracket, relaxation rate by reciprocal of 5, drag products
    assign kp  = 38'(s20_xk_reg[18:0]) * 38'(hsf_pkg::KT_RECIP);
    assign vmx = s20_e_reg.wx[15] ? (16'd0 - s20_e_reg.wx) : s20_e_reg.wx;
    assign vmy = s20_e_reg.wy[15] ? (16'd0 - s20_e_reg.wy) : s20_e_reg.wy;
    assign vmz = s20_e_reg.wz[15] ? (16'd0 - s20_e_reg.wz) : s20_e_reg.wz;

    always_comb
    begin
        s21_l_next    = s20_l_reg;
        s21_l_next.kt = (s20_xk_reg >= hsf_pkg::KT_SAT_LIMIT) ? hsf_pkg::RATE_MAX
                                                                : kp[36:21];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s21_e_reg   <= s20_e_reg;
            s21_l_reg   <= s21_l_next;
            s21_br_reg  <= hsf_pkg::BRACKET_BASE - 29'(s20_e_reg.term60)
                         + (s20_t2neg_reg ? 29'(s20_t2_reg) : (29'd0 - 29'(s20_t2_reg)));
            s21_dpx_reg <= 50'(s20_mkf_reg) * 50'(vmx);
            s21_dpy_reg <= 50'(s20_mkf_reg) * 50'(vmy);
            s21_dpz_reg <= 50'(s20_mkf_reg) * 50'(vmz);
            s21_nx_reg  <= !s20_e_reg.wx[15] && (s20_e_reg.wx != '0);
            s21_ny_reg  <= !s20_e_reg.wy[15] && (s20_e_reg.wy != '0);
            s21_nz_reg  <= !s20_e_reg.wz[15] && (s20_e_reg.wz != '0);
        end
    end

    // stage 22: bracket * exner, mass * kt, signed drags
    assign bmag = s21_br_reg[28] ? 28'(29'd0 - s21_br_reg) : s21_br_reg[27:0];

    always_comb
    begin
        s22_l_next        = s21_l_reg;
        s22_l_next.drag_x = s21_nx_reg ? (32'd0 - 32'(s21_dpx_reg[49:20]))
                                       : 32'(s21_dpx_reg[49:20]);
        s22_l_next.drag_y = s21_ny_reg ? (32'd0 - 32'(s21_dpy_reg[49:20]))
                                       : 32'(s21_dpy_reg[49:20]);
        s22_l_next.drag_z = s21_nz_reg ? (32'd0 - 32'(s21_dpz_reg[49:20]))
                                       : 32'(s21_dpz_reg[49:20]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s22_e_reg     <= s21_e_reg;
            s22_l_reg     <= s22_l_next;
            s22_tprod_reg <= 46'(bmag) * 46'(s21_e_reg.ex);
            s22_bneg_reg  <= s21_br_reg[28];
            s22_mk_reg    <= 34'(s21_e_reg.mass) * 34'(s21_l_reg.kt);
        end
    end

    // stage 23: equilibrium temperature with floor and ceiling
    assign tq = s22_tprod_reg[45:26];

    always_comb
    begin
        s23_l_next = s22_l_reg;
        priority if (s22_bneg_reg || (tq < 20'(hsf_pkg::TEQ_FLOOR)))
        begin
            s23_l_next.teq = hsf_pkg::TEQ_FLOOR;
        end
        else if (tq > 20'(hsf_pkg::RATE_MAX))
        begin
            s23_l_next.teq = hsf_pkg::RATE_MAX;
        end
        else
        begin
            s23_l_next.teq = tq[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s23_e_reg  <= s22_e_reg;
            s23_l_reg  <= s23_l_next;
            s23_mk_reg <= s22_mk_reg;
        end
    end

    // stage 24: temperature departure
    assign dt = {1'b0, s23_e_reg.temp} - {1'b0, s23_l_reg.teq};

    always_comb
    begin
        s24_l_next       = s23_l_reg;
        s24_l_next.dtpos = !dt[16] && (dt != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s24_e_reg   <= s23_e_reg;
            s24_l_reg   <= s24_l_next;
            s24_mk_reg  <= s23_mk_reg;
            s24_adt_reg <= dt[16] ? 16'(17'd0 - dt) : dt[15:0];
        end
    end

    // stage 25: tendency numerator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s25_e_reg   <= s24_e_reg;
            s25_l_reg   <= s24_l_reg;
            s25_num_reg <= 50'(s24_mk_reg) * 50'(s24_adt_reg);
        end
    end

    // stage 26: divisor and overflow test against 2^31 quotient
    always_comb
    begin
        s26_l_next     = s25_l_reg;
        s26_l_next.bad = s25_e_reg.bad;
        s26_l_next.ovf = 20'(s25_num_reg[49:31]) >= {s25_e_reg.ex, 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s26_l_reg   <= s26_l_next;
            s26_num_reg <= s25_num_reg;
            s26_den_reg <= {s25_e_reg.ex, 2'b00};
        end
    end

    hsf_div #(
        .NW (50),
        .DW (20),
        .QB (hsf_pkg::TH_QB)
    ) u_theta_div (
        .clk  (clk),
        .adv  (adv),
        .num  (s26_num_reg),
        .den  (s26_den_reg),
        .quot (q57)
    );

    hsf_dly #(
        .W     ($bits(hsf_pkg::hsf_late_t)),
        .DEPTH (hsf_pkg::TH_QB)
    ) u_late_dly (
        .clk (clk),
        .adv (adv),
        .d   (s26_l_reg),
        .q   (l57)
    );

    // output stage: sign and saturate the tendency, zero every field of a bad beat
    assign qc    = l57.ovf ? 32'h8000_0000 : {1'b0, q57};
    assign theta = l57.dtpos ? (32'd0 - qc) : (l57.ovf ? 32'h7FFF_FFFF : qc);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_bad_reg <= l57.bad;
            if (l57.bad)
            begin
                o_theta_reg <= '0;
                o_dx_reg    <= '0;
                o_dy_reg    <= '0;
                o_dz_reg    <= '0;
                o_teq_reg   <= '0;
                o_kt_reg    <= '0;
                o_kf_reg    <= '0;
            end
            else
            begin
                o_theta_reg <= theta;
                o_dx_reg    <= l57.drag_x;
                o_dy_reg    <= l57.drag_y;
                o_dz_reg    <= l57.drag_z;
                o_teq_reg   <= l57.teq;
                o_kt_reg    <= l57.kt;
                o_kf_reg    <= l57.kf;
            end
        end
    end

    assign forcing.valid               = vld_reg[ND-1];
    assign forcing.theta_mass_tendency = o_theta_reg;
    assign forcing.drag_x              = o_dx_reg;
    assign forcing.drag_y              = o_dy_reg;
    assign forcing.drag_z              = o_dz_reg;
    assign forcing.equilibrium_temp    = o_teq_reg;
    assign forcing.relax_rate          = o_kt_reg;
    assign forcing.drag_rate           = o_kf_reg;
    assign forcing.bad_input           = o_bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        forcing.valid && forcing.bad_input |->
            forcing.theta_mass_tendency == 0 && forcing.drag_x == 0 && forcing.drag_y == 0
            && forcing.drag_z == 0 && forcing.equilibrium_temp == 0
            && forcing.relax_rate == 0 && forcing.drag_rate == 0)
        else $error("bad beat carries nonzero fields");

    a_teq_floor: assert property (@(posedge clk) disable iff (!rst_n)
        forcing.valid && !forcing.bad_input |-> forcing.equilibrium_temp >= hsf_pkg::TEQ_FLOOR)
        else $error("equilibrium temperature below floor");

    a_relax_min: assert property (@(posedge clk) disable iff (!rst_n)
        forcing.valid && !forcing.bad_input |-> forcing.relax_rate >= hsf_pkg::KT_MIN)
        else $error("relaxation rate below base rate");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        forcing.valid && !forcing.ready |=> $stable(vld_reg))
        else $error("pipe moved during output stall");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic signed [15:0] sl;
        logic [15:0]        cl;
        logic [16:0]        p;
        logic [16:0]        ps;
        logic [17:0]        ex;
        logic [15:0]        t;
        logic [17:0]        m;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
    } point_t;

    typedef struct packed {
        logic signed [31:0] th;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [15:0]        teq;
        logic [15:0]        kt;
        logic [15:0]        kf;
        logic               bad;
    } force_t;

    typedef struct {
        point_t pt;
        logic   has_exp;
        force_t exp_f;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [16:0] cfg_wr_data = '0;

    hsf_point_if grid_point ();
    hsf_force_if forcing ();

    held_suarez_forcing_point_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .grid_point (grid_point.sink),
        .forcing    (forcing.source)
    );

    always #6 clk = ~clk;

    logic [16:0] pref_model = hsf_pkg::PREF_RESET;
    force_t      pending_forcing[$];
    int          errors = 0;
    int          cycles = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          hold_off = 0;

    function automatic logic [31:0] ln_q16(logic [31:0] x);
        int          k;
        logic [63:0] y;
        logic [31:0] frac;
        logic [63:0] l2;
        k = 0;
        frac = '0;
        while (k < 31 && (x >> (k + 1)) != 0)
            k++;
        y = 64'(x) << (31 - k);
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000)
            begin
                y = y >> 1;
                frac[15 - i] = 1'b1;
            end
        end
        l2 = (64'(k) << 16) | 64'(frac);
        return 32'((l2 * 64'(hsf_pkg::LN2_Q32)) >> 32);
    endfunction

    function automatic logic [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // magnitude is always far below 2^63 here, so no extra clamp needed
    function automatic logic signed [63:0] apply_sign(bit neg, logic [63:0] mag);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic force_t predict_forcing(point_t pt, logic [16:0] pref);
        force_t             f;
        logic signed [63:0] lnr, bracket, teq, dt, s;
        logic [63:0]        sa, c2, c4, w, kt, kf, num, lmag, ct;
        logic signed [63:0] v[3];
        f = '0;
        if (pt.p == 0 || pt.ps == 0 || pt.p > pt.ps || pref == 0 || pt.ex == 0)
        begin
            f.bad = 1'b1;
            return f;
        end
        lnr = $signed(64'(ln_q16(32'(pt.p)))) - $signed(64'(ln_q16(32'(pref))));
        s = 64'(pt.sl);
        sa = s < 0 ? 64'(-s) : 64'(s);
        c2 = 64'(pt.cl) * 64'(pt.cl);
        lmag = lnr < 0 ? 64'(-lnr * 10) : 64'(lnr * 10);
        ct = (lmag * c2) >> 30;
        bracket = 64'sd20643840 - $signed((64'd60 * sa * sa) >> 14)
                  - apply_sign(lnr < 0, ct);
        teq = apply_sign(bracket < 0,
                         ((bracket < 0 ? 64'(-bracket) : 64'(bracket)) * 64'(pt.ex)) >> 26);
        if (teq < 12800)
            teq = 12800;
        if (teq > 65535)
            teq = 65535;
        if (64'd10 * pt.p > 64'd7 * pt.ps)
            w = ((64'd10 * pt.p - 64'd7 * pt.ps) << 16) / (64'd3 * pt.ps);
        else
            w = 0;
        c2 = c2 >> 14;
        c4 = (c2 * c2) >> 16;
        kt = (64'h1_0000_0000 + 64'd9 * w * c4) / 64'd2621440;
        if (kt > 65535)
            kt = 65535;
        kf = w > 65535 ? 64'd65535 : w;
        dt = $signed(64'(pt.t)) - teq;
        num = 64'(pt.m) * kt * (dt < 0 ? 64'(-dt) : 64'(dt));
        f.th = clamp32(apply_sign(dt > 0, num / (64'(pt.ex) << 2)));
        v[0] = 64'(pt.vx);
        v[1] = 64'(pt.vy);
        v[2] = 64'(pt.vz);
        f.dx = clamp32(apply_sign(v[0] > 0,
                       (64'(pt.m) * kf * (v[0] < 0 ? 64'(-v[0]) : 64'(v[0]))) >> 20));
        f.dy = clamp32(apply_sign(v[1] > 0,
                       (64'(pt.m) * kf * (v[1] < 0 ? 64'(-v[1]) : 64'(v[1]))) >> 20));
        f.dz = clamp32(apply_sign(v[2] > 0,
                       (64'(pt.m) * kf * (v[2] < 0 ? 64'(-v[2]) : 64'(v[2]))) >> 20));
        f.teq = teq[15:0];
        f.kt = kt[15:0];
        f.kf = kf[15:0];
        return f;
    endfunction

    initial
    begin
        grid_point.valid = 1'b0;
        {grid_point.lat_sin, grid_point.lat_cos, grid_point.point_pressure,
         grid_point.ground_pressure, grid_point.exner_factor, grid_point.air_temperature,
         grid_point.layer_mass, grid_point.wind_x, grid_point.wind_y,
         grid_point.wind_z} = '0;
        forcing.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: compare every accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        force_t got, want;
        if (rst_n && forcing.valid && forcing.ready)
        begin
            got = {forcing.theta_mass_tendency, forcing.drag_x, forcing.drag_y,
                   forcing.drag_z, forcing.equilibrium_temp, forcing.relax_rate,
                   forcing.drag_rate, forcing.bad_input};
            if (pending_forcing.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_forcing.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: mismatch expected th=%0d dx=%0d dy=%0d dz=%0d",
                              " teq=%0d kt=%0d kf=%0d bad=%0b"},
                             $time, want.th, want.dx, want.dy, want.dz, want.teq, want.kt,
                             want.kf, want.bad);
                    $display({"%0t:          actual   th=%0d dx=%0d dy=%0d dz=%0d",
                              " teq=%0d kt=%0d kf=%0d bad=%0b"},
                             $time, got.th, got.dx, got.dy, got.dz, got.teq, got.kt,
                             got.kf, got.bad);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            forcing.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            forcing.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_point(point_t pt, force_t exp_f, bit typed);
        force_t pred;
        pred = predict_forcing(pt, pref_model);
        if (typed && pred !== exp_f)
        begin
            $display("%0t: table row disagrees with prediction expected %h actual %h",
                     $time, exp_f, pred);
            errors++;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            grid_point.valid <= 1'b0;
            @(negedge clk);
        end
        grid_point.valid <= 1'b1;
        {grid_point.lat_sin, grid_point.lat_cos, grid_point.point_pressure,
         grid_point.ground_pressure, grid_point.exner_factor, grid_point.air_temperature,
         grid_point.layer_mass, grid_point.wind_x, grid_point.wind_y,
         grid_point.wind_z} <= pt;
        do
            @(posedge clk);
        while (!grid_point.ready);
        pending_forcing.push_back(typed ? exp_f : pred);
        @(negedge clk);
    endtask

    task automatic settle_and_write(logic [16:0] value);
        grid_point.valid <= 1'b0;
        while (pending_forcing.size() != 0)
            @(negedge clk);
        repeat (hsf_pkg::PIPE_DEPTH + 4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        pref_model = value;
    endtask

    function automatic point_t random_point();
        point_t pt;
        int     mode;
        pt.sl = 16'($urandom);
        pt.cl = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(32768));
        pt.ps = 17'($urandom_range(131071, 1));
        mode = $urandom_range(9);
        if (mode == 0)
            pt.p = 17'($urandom);
        else if (mode == 1)
            pt.p = 0;
        else
            pt.p = 17'($urandom_range(pt.ps, 1));
        pt.ex = $urandom_range(9) == 0 ? 18'($urandom) : 18'($urandom_range(78000, 40000));
        pt.t = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(20000, 12000));
        pt.m = 18'($urandom);
        pt.vx = 16'($urandom);
        pt.vy = 16'($urandom);
        pt.vz = 16'($urandom);
        return pt;
    endfunction

    function automatic row_t mk(point_t pt, logic has_exp, force_t f);
        row_t r;
        r.pt = pt;
        r.has_exp = has_exp;
        r.exp_f = f;
        return r;
    endfunction

    localparam force_t BAD_RESULT = {176'b0, 1'b1};
    localparam point_t NOMINAL = {16'sd16384, 16'd28378, 17'd50000, 17'd100000,
                                  18'd65536, 16'd19200, 18'd1600, 16'sd2560,
                                  -16'sd2560, 16'sd0};
    localparam force_t NOMINAL_NONE = '0;

    initial
    begin
        row_t        tbl[$];
        point_t      pt;
        logic [16:0] prefs[4];
        prefs = '{17'd1, 17'd131071, 17'd50000, 17'd100000};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        src_idle_pct = 37;
        snk_idle_pct = 82;

        pt = NOMINAL; pt.p = 0;
        tbl.push_back(mk(pt, 1, BAD_RESULT));
        pt = NOMINAL; pt.ps = 0;
        tbl.push_back(mk(pt, 1, BAD_RESULT));
        pt = NOMINAL; pt.p = 100001;
        tbl.push_back(mk(pt, 1, BAD_RESULT));
        pt = NOMINAL; pt.ex = 0;
        tbl.push_back(mk(pt, 1, BAD_RESULT));
        tbl.push_back(mk(NOMINAL, 0, NOMINAL_NONE));
        // at the pole with a tiny exner and no mass the floor holds, tendencies vanish
        pt = NOMINAL; pt.sl = 16'sh7FFF; pt.cl = 0; pt.p = 1; pt.ex = 1;
        pt.t = 0; pt.m = 0; pt.vx = 0; pt.vy = 0; pt.vz = 0;
        tbl.push_back(mk(pt, 1, {96'b0, 32'sd0, 16'd12800, 16'd1638, 16'd0, 1'b0}));
        pt = NOMINAL; pt.p = 100000; pt.cl = 16'hFFFF; pt.m = 18'h3FFFF;
        pt.vx = 16'sh7FFF; pt.vy = 16'sh8000; pt.vz = 16'sh8000;
        tbl.push_back(mk(pt, 0, NOMINAL_NONE));
        pt = NOMINAL; pt.sl = 16'sh8000; pt.cl = 16'd32768; pt.p = 131071;
        pt.ps = 131071; pt.ex = 18'h3FFFF; pt.t = 16'hFFFF; pt.m = 18'h3FFFF;
        tbl.push_back(mk(pt, 0, NOMINAL_NONE));
        pt = NOMINAL; pt.p = 1; pt.ps = 1; pt.t = 16'hFFFF; pt.ex = 1;
        tbl.push_back(mk(pt, 0, NOMINAL_NONE));
        pt = NOMINAL; pt.p = 70000; pt.ps = 100000;
        tbl.push_back(mk(pt, 0, NOMINAL_NONE));
        pt = NOMINAL; pt.p = 131071; pt.ps = 131071; pt.cl = 16'd32768; pt.sl = 0;
        pt.ex = 18'd65536; pt.t = 0; pt.m = 18'h3FFFF;
        tbl.push_back(mk(pt, 0, NOMINAL_NONE));
        pt = NOMINAL; pt.ex = 18'h3FFFF; pt.sl = 0; pt.cl = 16'd32768;
        tbl.push_back(mk(pt, 0, NOMINAL_NONE));

        foreach (tbl[i])
            send_point(tbl[i].pt, tbl[i].exp_f, tbl[i].has_exp);

        // pref extremes, including its reset value last
        foreach (prefs[j])
        begin
            settle_and_write(prefs[j]);
            for (int n = 0; n < 40; n++)
                send_point(random_point(), NOMINAL_NONE, 0);
        end

        // pile items up behind a long receiver stall
        hold_off = 300;
        for (int n = 0; n < 100; n++)
            send_point(random_point(), NOMINAL_NONE, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = ph == 0 ? 37 : (ph == 1 ? 82 : 0);
            snk_idle_pct = ph == 0 ? 82 : (ph == 1 ? 37 : 0);
            if (ph == 1)
                settle_and_write(17'($urandom_range(131071, 1)));
            if (ph == 2)
                settle_and_write(17'd100000);
            for (int n = 0; n < 360; n++)
                send_point(random_point(), NOMINAL_NONE, 0);
        end

        grid_point.valid <= 1'b0;
        while (pending_forcing.size() != 0)
            @(negedge clk);
        repeat (hsf_pkg::PIPE_DEPTH + 10) @(negedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
